// ===== rtl/keypad_precedence_calculator_unit_macros.svh =====
// Assertion macros shared by the calculator RTL.
`ifndef KEYPAD_PRECEDENCE_CALCULATOR_UNIT_MACROS_SVH
`define KEYPAD_PRECEDENCE_CALCULATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define KPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define KPC_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `KPC_ASSERT(lbl, clk, rstn, !(expr), msg)
`else
`define KPC_ASSERT(lbl, clk, rstn, prop, msg)
`define KPC_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ===== rtl/kpc_pkg.sv =====
// Shared types and constants of the keypad calculator.
package kpc_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [7:0] KEY_MUL = 8'h2A;
  localparam logic [7:0] KEY_DIV = 8'h2F;
  localparam logic [7:0] KEY_ADD = 8'h2B;
  localparam logic [7:0] KEY_SUB = 8'h2D;
  localparam logic [7:0] KEY_EQ  = 8'h3D;
  localparam logic [7:0] KEY_CLR = 8'h63;
  localparam logic [7:0] KEY_D0  = 8'h30;
  localparam logic [7:0] KEY_D9  = 8'h39;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_MUL,
    OP_DIV,
    OP_ADD,
    OP_SUB,
    OP_EQ,
    OP_CLR
  } kpc_op_e;

  typedef struct packed {
    kpc_op_e    op;
    logic [3:0] digit;
  } kpc_cmd_t;

  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } kpc_md_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } kpc_md_rsp_t;

endpackage

// ===== rtl/keypad_precedence_calculator_unit.sv =====
// Keypad calculator with multiply and divide taking precedence over add and subtract.
//
// Each request carries one ASCII key. Keys are classified on entry and held in a
// short command queue, so new keys are taken while the evaluator is busy or a
// result waits at the output. An operator or '=' that closes a pending multiply,
// or a divide by a nonzero operand, waits on the shared multiply/divide unit,
// which resolves one bit per cycle; a divide by zero closes without that unit.
// '=' then loads the output register once it is free, and the result stays
// there until it is taken. Division truncates towards zero; a zero divisor
// gives a result of 0 with divide_by_zero set. Unknown keys are dropped.
module keypad_precedence_calculator_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               divide_by_zero_o
);
  import kpc_pkg::*;

  logic        push, pop, q_full, q_empty;
  kpc_cmd_t    push_cmd, head_cmd;
  kpc_md_req_t md_req;
  kpc_md_rsp_t md_rsp;

  kpc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .key_i      (key_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  kpc_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  kpc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  kpc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (head_cmd),
    .q_empty_i        (q_empty),
    .pop_o            (pop),
    .md_req_o         (md_req),
    .md_rsp_i         (md_rsp),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

// ===== rtl/kpc_front.sv =====
// Front end: accepts key requests and turns them into queued commands.
module kpc_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        key_i,
  input  logic              q_full_i,
  output logic              push_o,
  output kpc_pkg::kpc_cmd_t cmd_o
);
  import kpc_pkg::*;

  logic known;

  always_comb begin
    known        = 1'b1;
    cmd_o.digit  = key_i[3:0];
    cmd_o.op     = OP_DIGIT;
    if (key_i inside {[KEY_D0:KEY_D9]}) begin
      cmd_o.op = OP_DIGIT;
    end else begin
      case (key_i)
        KEY_MUL: cmd_o.op = OP_MUL;
        KEY_DIV: cmd_o.op = OP_DIV;
        KEY_ADD: cmd_o.op = OP_ADD;
        KEY_SUB: cmd_o.op = OP_SUB;
        KEY_EQ:  cmd_o.op = OP_EQ;
        KEY_CLR: cmd_o.op = OP_CLR;
        default: known = 1'b0;
      endcase
    end
  end

  // Unknown keys are taken and dropped without touching the queue.
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && known;

endmodule

// ===== rtl/kpc_queue.sv =====
// Short command queue between the front end and the evaluator.
`include "keypad_precedence_calculator_unit_macros.svh"
module kpc_queue #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kpc_pkg::kpc_cmd_t cmd_i,
  input  logic              pop_i,
  output kpc_pkg::kpc_cmd_t cmd_o,
  output logic              full_o,
  output logic              empty_o
);
  import kpc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  kpc_cmd_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `KPC_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "queue written while full")
  `KPC_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "queue read while empty")

endmodule

// ===== rtl/kpc_muldiv.sv =====
// Shared one-bit-per-cycle multiplier and signed truncating divider.
`include "keypad_precedence_calculator_unit_macros.svh"
module kpc_muldiv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kpc_pkg::kpc_md_req_t req_i,
  output kpc_pkg::kpc_md_rsp_t rsp_o
);
  import kpc_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q, done_q, div_q, neg_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] acc_q, opa_q, opb_q, res_q;

  logic [DataW:0]   rem_sh;
  logic             fits;
  logic [DataW-1:0] acc_d, opa_d;
  logic [DataW-1:0] mag_a, mag_b;

  assign mag_a = req_i.a[DataW-1] ? (DataW'(0) - req_i.a) : req_i.a;
  assign mag_b = req_i.b[DataW-1] ? (DataW'(0) - req_i.b) : req_i.b;

  always_comb begin
    rem_sh = {acc_q, opa_q[DataW-1]};
    fits   = (rem_sh >= {1'b0, opb_q});
    if (div_q) begin
      acc_d = fits ? DataW'(rem_sh - {1'b0, opb_q}) : rem_sh[DataW-1:0];
      opa_d = {opa_q[DataW-2:0], fits};
    end else begin
      acc_d = opb_q[0] ? (acc_q + opa_q) : acc_q;
      opa_d = {opa_q[DataW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      opa_q  <= '0;
      opb_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        div_q  <= req_i.is_div;
        neg_q  <= req_i.a[DataW-1] ^ req_i.b[DataW-1];
        cnt_q  <= '1;
        acc_q  <= '0;
        opa_q  <= req_i.is_div ? mag_a : req_i.a;
        opb_q  <= req_i.is_div ? mag_b : req_i.b;
      end else if (busy_q) begin
        acc_q <= acc_d;
        opa_q <= opa_d;
        if (!div_q) begin
          opb_q <= {1'b0, opb_q[DataW-1:1]};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          if (div_q) begin
            res_q <= neg_q ? (DataW'(0) - opa_d) : opa_d;
          end else begin
            res_q <= acc_d;
          end
        end
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  `KPC_ASSERT_NEVER(a_start_idle, clk_i, rst_ni, req_i.start && busy_q, "start while busy")
  `KPC_ASSERT(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "done held for two cycles")

endmodule

// ===== rtl/kpc_back.sv =====
// Evaluator: runs queued commands against the running sum and product term.
`include "keypad_precedence_calculator_unit_macros.svh"
module kpc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kpc_pkg::kpc_cmd_t         cmd_i,
  input  logic                      q_empty_i,
  output logic                      pop_o,
  output kpc_pkg::kpc_md_req_t      md_req_o,
  input  kpc_pkg::kpc_md_rsp_t      md_rsp_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [31:0]        value_o,
  output logic                      divide_by_zero_o
);
  import kpc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_EMIT} state_e;
  typedef enum logic [1:0] {PEND_NONE, PEND_MUL, PEND_DIV} pend_e;

  state_e           state_q;
  pend_e            pend_q;
  kpc_op_e          op_q;
  logic [DataW-1:0] entry_q, product_q, sum_q;
  logic             neg_q, zdiv_q;
  logic             out_valid_q, out_dbz_q;
  logic [DataW-1:0] out_value_q;

  logic             is_oper, need_md, apply_en, dz_set;
  kpc_op_e          apply_op;
  logic [DataW-1:0] close_t, direct_t, sum_d, entry_d;

  always_comb begin
    pop_o    = (state_q == S_IDLE) && !q_empty_i;
    is_oper  = (cmd_i.op != OP_DIGIT) && (cmd_i.op != OP_CLR);
    need_md  = (pend_q == PEND_MUL) || ((pend_q == PEND_DIV) && (entry_q != '0));
    dz_set   = pop_o && is_oper && (pend_q == PEND_DIV) && (entry_q == '0);
    direct_t = (pend_q == PEND_DIV) ? '0 : entry_q;
    apply_en = (pop_o && is_oper && !need_md) || ((state_q == S_WAIT) && md_rsp_i.done);
    apply_op = (state_q == S_WAIT) ? op_q : cmd_i.op;
    close_t  = (state_q == S_WAIT) ? md_rsp_i.result : direct_t;
    sum_d    = neg_q ? (sum_q - close_t) : (sum_q + close_t);
    entry_d  = (entry_q << 3) + (entry_q << 1) + {{(DataW-4){1'b0}}, cmd_i.digit};

    md_req_o.start  = pop_o && is_oper && need_md;
    md_req_o.is_div = (pend_q == PEND_DIV);
    md_req_o.a      = product_q;
    md_req_o.b      = entry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= PEND_NONE;
      op_q        <= OP_DIGIT;
      entry_q     <= '0;
      product_q   <= '0;
      sum_q       <= '0;
      neg_q       <= 1'b0;
      zdiv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_dbz_q   <= 1'b0;
      out_value_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      if (dz_set) begin
        zdiv_q <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            op_q <= cmd_i.op;
            case (cmd_i.op)
              OP_DIGIT: entry_q <= entry_d;
              OP_CLR: begin
                pend_q    <= PEND_NONE;
                entry_q   <= '0;
                product_q <= '0;
                sum_q     <= '0;
                neg_q     <= 1'b0;
                zdiv_q    <= 1'b0;
              end
              default: begin
                if (need_md) begin
                  state_q <= S_WAIT;
                end
              end
            endcase
          end
        end
        S_WAIT: begin
          if (md_rsp_i.done && (op_q != OP_EQ)) begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_value_q <= zdiv_q ? '0 : sum_q;
            out_dbz_q   <= zdiv_q;
            sum_q       <= '0;
            zdiv_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (apply_en) begin
        entry_q <= '0;
        if ((apply_op == OP_MUL) || (apply_op == OP_DIV)) begin
          product_q <= close_t;
          pend_q    <= (apply_op == OP_MUL) ? PEND_MUL : PEND_DIV;
        end else begin
          sum_q     <= sum_d;
          product_q <= '0;
          pend_q    <= PEND_NONE;
          neg_q     <= (apply_op == OP_SUB);
          if (apply_op == OP_EQ) begin
            state_q <= S_EMIT;
          end
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = out_value_q;
  assign divide_by_zero_o = out_dbz_q;

  `KPC_ASSERT(a_emit_source, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_EMIT), "result without evaluation")
  `KPC_ASSERT(a_dbz_zero, clk_i, rst_ni, (out_valid_q && out_dbz_q) |-> (out_value_q == '0), "nonzero value with zero divisor")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the keypad precedence calculator unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kpc_pkg::*;

  localparam int CycleLimit  = 800_000;
  localparam int DrainCycles = 64;
  localparam int KeyTarget   = 2000;
  localparam int MaxReported = 10;

  localparam logic [7:0] OperatorKeys [4] = '{KEY_MUL, KEY_DIV, KEY_ADD, KEY_SUB};
  localparam logic [31:0] EdgeOperands [5] =
    '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};

  typedef enum logic [1:0] {
    TERM_NONE,
    TERM_MUL,
    TERM_DIV
  } term_op_e;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_SPARSE,
    READY_LONG_STALL
  } ready_mode_e;

  typedef struct packed {
    logic [31:0] value;
    logic        divide_by_zero;
  } calc_result_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         key_i = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] value_o;
  logic               divide_by_zero_o;

  logic [31:0] typed_operand = '0;
  logic [31:0] term_product = '0;
  term_op_e    term_op = TERM_NONE;
  logic        term_subtract = 1'b0;
  logic [31:0] partial_sum = '0;
  logic        zero_divisor = 1'b0;

  calc_result_t expected_results[$];
  int          error_count = 0;
  int          keys_counted = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  logic [15:0] ready_tick = '0;
  ready_mode_e ready_mode = READY_ALWAYS;

  keypad_precedence_calculator_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .key_i            (key_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic key_is_handled(input logic [7:0] key);
    return (key >= KEY_D0 && key <= KEY_D9) || key == KEY_MUL || key == KEY_DIV ||
           key == KEY_ADD || key == KEY_SUB || key == KEY_EQ || key == KEY_CLR;
  endfunction

  function automatic void clear_calculator();
    typed_operand = '0;
    term_product  = '0;
    term_op       = TERM_NONE;
    term_subtract = 1'b0;
    partial_sum   = '0;
    zero_divisor  = 1'b0;
  endfunction

  function automatic logic [31:0] truncated_quotient(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quot;
    mag_a = a[31] ? 32'd0 - a : a;
    mag_b = b[31] ? 32'd0 - b : b;
    quot  = mag_a / mag_b;
    return (a[31] != b[31]) ? 32'd0 - quot : quot;
  endfunction

  function automatic logic [31:0] closed_term();
    logic [31:0] term;
    term = typed_operand;
    case (term_op)
      TERM_MUL: term = term_product * typed_operand;
      TERM_DIV: begin
        if (typed_operand == 32'd0) begin
          zero_divisor = 1'b1;
          term = 32'd0;
        end else begin
          term = truncated_quotient(term_product, typed_operand);
        end
      end
      default: ;
    endcase
    return term;
  endfunction

  function automatic void evaluate_key(input logic [7:0] key);
    logic [31:0]  term;
    calc_result_t answer;
    if (key >= KEY_D0 && key <= KEY_D9) begin
      typed_operand = typed_operand * 32'd10 + 32'(key - KEY_D0);
    end else if (key == KEY_MUL || key == KEY_DIV) begin
      term_product  = closed_term();
      term_op       = (key == KEY_MUL) ? TERM_MUL : TERM_DIV;
      typed_operand = '0;
    end else if (key == KEY_ADD || key == KEY_SUB || key == KEY_EQ) begin
      term          = closed_term();
      partial_sum   = term_subtract ? partial_sum - term : partial_sum + term;
      term_op       = TERM_NONE;
      term_subtract = (key == KEY_SUB);
      typed_operand = '0;
      term_product  = '0;
      if (key == KEY_EQ) begin
        answer.value          = zero_divisor ? 32'd0 : partial_sum;
        answer.divide_by_zero = zero_divisor;
        expected_results.push_back(answer);
        clear_calculator();
      end
    end else if (key == KEY_CLR) begin
      clear_calculator();
    end
  endfunction

  always @(posedge clk_i) begin
    calc_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) evaluate_key(key_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          if (error_count < MaxReported)
            $display("Unexpected result: value %0d divide_by_zero %0b",
                     value_o, divide_by_zero_o);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (value_o !== want.value || divide_by_zero_o !== want.divide_by_zero) begin
            if (error_count < MaxReported)
              $display("Mismatch: expected value %0d dz %0b, got value %0d dz %0b",
                       $signed(want.value), want.divide_by_zero, value_o, divide_by_zero_o);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    ready_tick <= ready_tick + 16'd1;
    if (ready_tick[6:0] == 7'd0) ready_mode <= ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready_i <= (ready_tick[2:0] == 3'd0);
      default:      out_ready_i <= (ready_tick[5:0] >= 6'd56);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_key(input logic [7:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    if (key_is_handled(key)) keys_counted++;
  endtask

  task automatic send_number(input logic [31:0] number);
    logic [7:0]  digits[$];
    logic [31:0] rest;
    rest = number;
    do begin
      digits.push_front(KEY_D0 + 8'(rest % 32'd10));
      rest = rest / 32'd10;
    end while (rest != 32'd0);
    foreach (digits[i]) send_key(digits[i]);
  endtask

  task automatic send_term(input logic [31:0] number, input logic [7:0] op_key);
    send_number(number);
    send_key(op_key);
  endtask

  function automatic logic [7:0] random_operator();
    return OperatorKeys[$urandom_range(0, 3)];
  endfunction

  task automatic send_random_operand();
    case ($urandom_range(0, 4))
      0:       send_number($urandom_range(0, 9));
      1:       send_number($urandom_range(0, 999));
      2:       send_number($urandom);
      3:       send_number(EdgeOperands[$urandom_range(0, 4)]);
      default: repeat ($urandom_range(11, 13)) send_key(KEY_D0 + 8'($urandom_range(0, 9)));
    endcase
  endtask

  task automatic send_random_expression();
    int terms;
    terms = $urandom_range(1, 6);
    if ($urandom_range(0, 15) == 0) begin
      send_term(32'h8000_0000, KEY_DIV);
      send_term(32'hFFFF_FFFF, random_operator());
    end
    for (int i = 0; i < terms; i++) begin
      if ($urandom_range(0, 15) != 0) send_random_operand();
      send_key((i == terms - 1) ? KEY_EQ : random_operator());
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_key(8'($urandom_range(0, 255)));
  endtask

  task automatic send_broken_expression();
    send_random_operand();
    send_key(random_operator());
    send_random_operand();
    if ($urandom_range(0, 1) == 1) send_key(KEY_CLR);
  endtask

  task automatic test_missing_operand();
    send_key(KEY_EQ);
    send_key(KEY_SUB);
    send_term(32'd5, KEY_EQ);
  endtask

  task automatic test_zero_divisor();
    send_term(32'd7, KEY_DIV);
    send_term(32'd0, KEY_ADD);
    send_term(32'd3, KEY_EQ);
  endtask

  task automatic test_precedence();
    send_term(32'd9, KEY_ADD);
    send_term(32'd2, KEY_MUL);
    send_term(32'd3, KEY_SUB);
    send_term(32'd8, KEY_DIV);
    send_term(32'd3, KEY_EQ);
  endtask

  task automatic test_clear_and_ignored();
    send_number(32'd5);
    send_key(8'hFF);
    send_key(KEY_CLR);
    send_key(8'h00);
    send_term(32'd2, KEY_EQ);
  endtask

  task automatic test_random_expressions(input int target);
    int pick;
    while (keys_counted < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) send_random_expression();
      else if (pick == 8) send_noise();
      else send_broken_expression();
    end
  endtask

  initial begin
    clear_calculator();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_missing_operand();
    test_zero_divisor();
    test_precedence();
    test_clear_and_ignored();
    test_random_expressions(KeyTarget);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
